FILE: hw/rtl/sem_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude block.
// No dependencies; the other files of the block, all but sem_line_mem, import this package.
`default_nettype none

package sem_pkg;

    localparam int CH_W     = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = CH_W * NUM_CH;
    localparam int DIM_W    = 11;
    localparam int GRAD_W   = 11;
    localparam int SQ_W     = 22;
    localparam int CFG_AW   = 1;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Register map of the configuration port.
    localparam logic [CFG_AW-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0]  DIM_RESET        = 11'd1024;

    typedef logic [PIX_W-1:0]        t_pix;
    typedef t_pix [8:0]              t_win;
    typedef logic signed [2:0]       t_coef;
    typedef logic signed [GRAD_W-1:0] t_grad_val;

    // Sobel kernels, row-major over the 3x3 neighborhood.
    localparam t_coef KERN_X [9] = '{-3'sd1, 3'sd0, 3'sd1,
                                     -3'sd2, 3'sd0, 3'sd2,
                                     -3'sd1, 3'sd0, 3'sd1};
    localparam t_coef KERN_Y [9] = '{-3'sd1, -3'sd2, -3'sd1,
                                      3'sd0,  3'sd0,  3'sd0,
                                      3'sd1,  3'sd2,  3'sd1};

    typedef struct packed {
        t_grad_val [NUM_CH-1:0] gx;
        t_grad_val [NUM_CH-1:0] gy;
        logic                   vld;
    } t_grad;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] mag;
        logic                        done;
    } t_mag;

endpackage

`default_nettype wire

FILE: hw/rtl/sobel_edge_magnitude_rgb_unit.sv
// Top level of the RGB Sobel edge magnitude block: control, window, outputs.
// Depends on sem_pkg, sem_line_mem, sem_grad and sem_isqrt.
//
//   Channel   Direction  Beat contents
//   s (input) in         tdata: red, green, blue; tuser: command (1 = flush)
//   m (result) out       tdata: red, green, blue edge; tuser: row_end;
//                        tlast: frame_end
//   cfg       in         index 0 = frame_width, 1 = frame_height; data 11 bits
//
// One input beat is handled at a time. A beat that yields no result passes
// through a line store read, then write-back and window shift. A beat that
// yields a result then also passes the gradient stage, the squares, and the
// 8-step square root loop, plus any wait for i_m_tready. Reset (synchronous,
// active low) clears the position counters, the window and the registers to
// 1024; line store contents need no clearing, because out-of-frame neighbors
// are masked by position. A stalled result simply holds the block until it
// is taken.
`default_nettype none

module sobel_edge_magnitude_rgb_unit #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Input beats.
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [sem_pkg::PIX_W-1:0]   i_s_tdata,   // red, green, blue
    input  wire logic                        i_s_tuser,   // command
    // Result beats.
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic      [sem_pkg::PIX_W-1:0]   o_m_tdata,   // red, green, blue edge
    output logic                             o_m_tuser,   // row_end
    output logic                             o_m_tlast,   // frame_end
    // Configuration writes.
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [sem_pkg::CFG_AW-1:0]  i_cfg_index,
    input  wire logic [sem_pkg::DIM_W-1:0]   i_cfg_data
);
    import sem_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HD_W  = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_ROOT,
        ST_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [DIM_W-1:0] r_frame_width, n_frame_width;
    logic [DIM_W-1:0] r_frame_height, n_frame_height;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_cur_row, n_cur_row;
    logic [COL_W-1:0] r_cur_col, n_cur_col;
    t_pix             r_pix, n_pix;
    t_win             r_win, n_win;
    t_win             r_fwin, n_fwin;
    logic             r_row_end, n_row_end;
    logic             r_frame_end, n_frame_end;
    logic [PIX_W-1:0] r_out_data, n_out_data;

    logic [WD_W-1:0]  w_clamp;
    logic [HD_W-1:0]  h_clamp;
    logic [COL_W-1:0] a_col;
    logic [ROW_W-1:0] a_row;
    logic [2*PIX_W-1:0] mem_rd;
    logic             mem_we;
    t_grad            grad;
    t_mag             mag;
    logic             s_fire;

    // Clamp the dimensions to 1..MAX.
    always_comb begin
        if (r_frame_width == '0) begin
            w_clamp = WD_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_clamp = WD_W'(MAX_WIDTH);
        end else begin
            w_clamp = WD_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_clamp = HD_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_clamp = HD_W'(MAX_HEIGHT);
        end else begin
            h_clamp = HD_W'(r_frame_height);
        end
    end

    // A width change mid-frame can leave the column past the row end.
    always_comb begin
        if (32'(r_col) >= 32'(w_clamp)) begin
            a_col = '0;
            a_row = ROW_W'(32'(r_row) + 1);
        end else begin
            a_col = r_col;
            a_row = r_row;
        end
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign mem_we      = (r_state == ST_READ);

    sem_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * PIX_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_addr (a_col),
        .o_rd_data (mem_rd),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_cur_col),
        .i_wr_data ({mem_rd[PIX_W-1:0], r_pix})
    );

    sem_grad u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_state == ST_GRAD),
        .i_win   (r_fwin),
        .o_grad  (grad)
    );

    sem_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_grad  (grad),
        .o_mag   (mag)
    );

    always_comb begin
        logic             case_a;
        logic             case_b;
        logic             emit;
        logic [ROW_W-1:0] cr;
        logic [COL_W-1:0] cc;
        logic [2:0]       row_ok;
        logic [2:0]       col_ok;
        t_win             post;
        t_pix             src;
        src            = '0;
        n_state        = r_state;
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_row          = r_row;
        n_col          = r_col;
        n_cur_row      = r_cur_row;
        n_cur_col      = r_cur_col;
        n_pix          = r_pix;
        n_win          = r_win;
        n_fwin         = r_fwin;
        n_row_end      = r_row_end;
        n_frame_end    = r_frame_end;
        n_out_data     = r_out_data;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  n_frame_width  = i_cfg_data;
                CFG_FRAME_HEIGHT: n_frame_height = i_cfg_data;
                default: ;
            endcase
        end

        // Window after the shift: new column from the line stores and pixel.
        for (int k = 0; k < 3; k++) begin
            post[k*3]     = r_win[k*3+1];
            post[k*3+1]   = r_win[k*3+2];
        end
        post[2] = mem_rd[2*PIX_W-1:PIX_W];
        post[5] = mem_rd[PIX_W-1:0];
        post[8] = r_pix;

        // The previous row's last result comes out at column 0 from the
        // unshifted window; every other result uses the shifted window.
        case_a = (r_cur_col == '0) && (32'(r_cur_row) >= 32'd2);
        case_b = (r_cur_col != '0) && (r_cur_row != '0);
        emit   = case_a || case_b;
        if (case_a) begin
            cr = ROW_W'(32'(r_cur_row) - 32'd2);
            cc = COL_W'(32'(w_clamp) - 32'd1);
        end else begin
            cr = ROW_W'(32'(r_cur_row) - 32'd1);
            cc = COL_W'(32'(r_cur_col) - 32'd1);
        end
        row_ok[0] = (cr != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = (32'(cr) + 32'd1) < 32'(h_clamp);
        col_ok[0] = (cc != '0);
        col_ok[1] = 1'b1;
        col_ok[2] = case_b && ((32'(cc) + 32'd1) < 32'(w_clamp));

        case (r_state)
            ST_IDLE: begin
                if (s_fire && !(i_s_tuser && r_row == '0 && r_col == '0)) begin
                    n_cur_row = a_row;
                    n_cur_col = a_col;
                    if (i_s_tuser || (32'(a_row) >= 32'(h_clamp))) begin
                        n_pix = '0;
                    end else begin
                        n_pix = {i_s_tdata[CH_W-1:0], i_s_tdata[2*CH_W-1:CH_W],
                                 i_s_tdata[PIX_W-1:2*CH_W]};
                    end
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        if (case_a) begin
                            src = (j < 2) ? r_win[i*3+j+1] : '0;
                        end else begin
                            src = post[i*3+j];
                        end
                        n_fwin[i*3+j] = (row_ok[i] && col_ok[j]) ? src : '0;
                    end
                end
                n_win       = post;
                n_row_end   = (32'(cc) + 32'd1) == 32'(w_clamp);
                n_frame_end = n_row_end && ((32'(cr) + 32'd1) >= 32'(h_clamp));
                if (emit && n_frame_end) begin
                    n_row = '0;
                    n_col = '0;
                end else if ((32'(r_cur_col) + 32'd1) >= 32'(w_clamp)) begin
                    n_col = '0;
                    n_row = ROW_W'(32'(r_cur_row) + 32'd1);
                end else begin
                    n_col = COL_W'(32'(r_cur_col) + 32'd1);
                    n_row = r_cur_row;
                end
                n_state = emit ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (mag.done) begin
                    n_out_data = {mag.mag[2], mag.mag[1], mag.mag[0]};
                    n_state    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_frame_width  <= DIM_RESET;
            r_frame_height <= DIM_RESET;
            r_row          <= '0;
            r_col          <= '0;
            r_win          <= '0;
        end else begin
            r_state        <= n_state;
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_row          <= n_row;
            r_col          <= n_col;
            r_win          <= n_win;
        end
        r_cur_row   <= n_cur_row;
        r_cur_col   <= n_cur_col;
        r_pix       <= n_pix;
        r_fwin      <= n_fwin;
        r_row_end   <= n_row_end;
        r_frame_end <= n_frame_end;
        r_out_data  <= n_out_data;
    end

    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_row_end;
    assign o_m_tlast  = r_frame_end;

endmodule

`default_nettype wire

FILE: hw/rtl/sem_line_mem.sv
// Line store memory: upper and lower line side by side in one word.
// Synchronous write, registered read. Depends on nothing.
`default_nettype none

module sem_line_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 48
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [DW-1:0]            o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DW-1:0]            i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sem_grad.sv
// Sobel Gx/Gy for the three channels of a masked 3x3 window, registered.
// Depends on sem_pkg.
`default_nettype none

module sem_grad (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire sem_pkg::t_win i_win,
    output sem_pkg::t_grad    o_grad
);
    import sem_pkg::*;

    t_grad n_grad;

    always_comb begin
        t_grad_val ax;
        t_grad_val ay;
        t_grad_val v;
        n_grad = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            ax = '0;
            ay = '0;
            for (int k = 0; k < 9; k++) begin
                v  = $signed(GRAD_W'(i_win[k][PIX_W-1-CH_W*ch -: CH_W]));
                ax = ax + GRAD_W'(KERN_X[k]) * v;
                ay = ay + GRAD_W'(KERN_Y[k]) * v;
            end
            n_grad.gx[ch] = ax;
            n_grad.gy[ch] = ay;
        end
        n_grad.vld = i_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_grad.vld <= 1'b0;
        end else begin
            o_grad.vld <= n_grad.vld;
        end
        if (i_en) begin
            o_grad.gx <= n_grad.gx;
            o_grad.gy <= n_grad.gy;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sem_isqrt.sv
// Gradient magnitude: squares, then an 8-step bit-by-bit integer square root
// per channel, saturating at 255. Depends on sem_pkg.
`default_nettype none

module sem_isqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sem_pkg::t_grad i_grad,
    output sem_pkg::t_mag      o_mag
);
    import sem_pkg::*;

    logic                         r_busy;
    logic                         r_done;
    logic [CH_W-1:0]              r_bit;
    logic [NUM_CH-1:0][SQ_W-1:0]  r_sum;
    logic [NUM_CH-1:0][CH_W-1:0]  r_root;

    logic [NUM_CH-1:0][SQ_W-1:0]  n_sum;
    logic [NUM_CH-1:0][CH_W-1:0]  n_root;

    always_comb begin
        logic signed [SQ_W-1:0] sqx;
        logic signed [SQ_W-1:0] sqy;
        logic [CH_W-1:0]        t;
        logic [2*CH_W-1:0]      tt;
        n_sum  = r_sum;
        n_root = r_root;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sqx = SQ_W'($signed(i_grad.gx[ch])) * SQ_W'($signed(i_grad.gx[ch]));
            sqy = SQ_W'($signed(i_grad.gy[ch])) * SQ_W'($signed(i_grad.gy[ch]));
            t   = r_root[ch] | r_bit;
            tt  = (2*CH_W)'(t) * (2*CH_W)'(t);
            if (i_grad.vld) begin
                n_sum[ch]  = unsigned'(sqx) + unsigned'(sqy);
                n_root[ch] = '0;
            end else if (r_busy && (SQ_W'(tt) <= r_sum[ch])) begin
                n_root[ch] = t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= r_busy && (r_bit == CH_W'(1));
            if (i_grad.vld) begin
                r_busy <= 1'b1;
                r_bit  <= {1'b1, {(CH_W-1){1'b0}}};
            end else if (r_busy) begin
                r_bit <= r_bit >> 1;
                if (r_bit == CH_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
        r_sum  <= n_sum;
        r_root <= n_root;
    end

    assign o_mag.mag  = r_root;
    assign o_mag.done = r_done;

endmodule

`default_nettype wire

FILE: bench/tb_sobel_edge_magnitude_rgb_unit.sv
// Self-checking bench for sobel_edge_magnitude_rgb_unit: random RGB frames
// of several sizes, flush drains and register changes, predicted in-bench.
// Depends on sem_pkg and the block's RTL.
`default_nettype none

class edge_scoreboard;
    // Expected result beats: {red, green, blue, row_end, frame_end}.
    logic [25:0] pending[$];
    int          errors;

    // Predictor state.
    int unsigned width_reg, height_reg;
    logic [23:0] upper_line[1024];
    logic [23:0] lower_line[1024];
    logic [23:0] win[9];
    int unsigned cur_row, cur_col;

    function new();
        errors = 0;
        width_reg = 1024;
        height_reg = 1024;
        foreach (win[k]) win[k] = '0;
        foreach (upper_line[k]) begin
            upper_line[k] = '0;
            lower_line[k] = '0;
        end
        cur_row = 0;
        cur_col = 0;
    endfunction

    function void write_reg(bit idx, int unsigned val);
        if (idx == sem_pkg::CFG_FRAME_WIDTH) width_reg = val;
        else height_reg = val;
    endfunction

    static function int unsigned clamp_dim(int unsigned v);
        if (v < 1) return 1;
        if (v > 1024) return 1024;
        return v;
    endfunction

    static function logic [7:0] root_sat(int gx, int gy);
        int unsigned s, r, t;
        s = gx * gx + gy * gy;
        r = 0;
        if (s >= 65536) return 8'hff;
        for (int b = 128; b != 0; b = b >> 1) begin
            t = r | b;
            if (t * t <= s) r = t;
        end
        return r[7:0];
    endfunction

    // Gradient magnitudes for centre (cr, cc) with the centre column at base.
    function logic [23:0] sobel_at(int cr, int cc, int base, int w, int h);
        int gx[3], gy[3];
        int kx[9], ky[9];
        int row, col, wc, k, v;
        logic [23:0] res;
        kx = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
        ky = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
        gx = '{0, 0, 0};
        gy = '{0, 0, 0};
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                row = cr + dy;
                col = cc + dx;
                wc = base + dx;
                k = (dy + 1) * 3 + dx + 1;
                if (row < 0 || row >= h || col < 0 || col >= w || wc > 2) continue;
                for (int ch = 0; ch < 3; ch++) begin
                    v = win[(dy + 1) * 3 + wc][23 - 8 * ch -: 8];
                    gx[ch] += kx[k] * v;
                    gy[ch] += ky[k] * v;
                end
            end
        end
        for (int ch = 0; ch < 3; ch++) res[23 - 8 * ch -: 8] = root_sat(gx[ch], gy[ch]);
        return res;
    endfunction

    // Notes an accepted input beat and queues the result it causes, if any.
    function void note_input(bit flush, logic [23:0] rgb);
        int unsigned w, h, r, c;
        int cr, cc;
        bit emit;
        logic [23:0] mag, up, lo, pix;
        logic rend, fend;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        emit = 0;
        pix = rgb;
        if (flush && cur_row == 0 && cur_col == 0) return;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        r = cur_row;
        c = cur_col;
        if (flush || r >= h) pix = '0;
        if (c == 0 && r >= 2) begin
            cr = r - 2;
            cc = w - 1;
            mag = sobel_at(cr, cc, 2, w, h);
            emit = 1;
        end
        up = upper_line[c];
        lo = lower_line[c];
        upper_line[c] = lo;
        lower_line[c] = pix;
        for (int k = 0; k < 3; k++) begin
            win[k * 3] = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = up;
        win[5] = lo;
        win[8] = pix;
        if (c >= 1 && r >= 1) begin
            cr = r - 1;
            cc = c - 1;
            mag = sobel_at(cr, cc, 1, w, h);
            emit = 1;
        end
        if (c + 1 >= w) begin
            cur_col = 0;
            cur_row = r + 1;
        end else begin
            cur_col = c + 1;
        end
        if (!emit) return;
        rend = (cc == w - 1);
        fend = 0;
        if (cr >= int'(h) - 1 && cc == w - 1) begin
            fend = 1;
            cur_row = 0;
            cur_col = 0;
        end
        pending.push_back({mag, rend, fend});
    endfunction

    function void check_result(logic [23:0] data, logic rend, logic fend);
        logic [25:0] exp_beat;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result beat data=%h row_end=%b frame_end=%b",
                     $time, data, rend, fend);
            errors++;
            return;
        end
        exp_beat = pending.pop_front();
        if (exp_beat[25:2] !== data) begin
            $display("%0t: edge data expected %h actual %h", $time, exp_beat[25:2], data);
            errors++;
        end
        if (exp_beat[1] !== rend) begin
            $display("%0t: row_end expected %b actual %b", $time, exp_beat[1], rend);
            errors++;
        end
        if (exp_beat[0] !== fend) begin
            $display("%0t: frame_end expected %b actual %b", $time, exp_beat[0], fend);
            errors++;
        end
    endfunction

    // True when the predictor sits at the start of a frame.
    function bit at_frame_start();
        return cur_row == 0 && cur_col == 0;
    endfunction
endclass

module tb_sobel_edge_magnitude_rgb_unit;
    import sem_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic [PIX_W-1:0] i_s_tdata = '0;
    logic i_s_tuser = 1'b0;
    logic i_m_tready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_AW-1:0] i_cfg_index = '0;
    logic [DIM_W-1:0] i_cfg_data = '0;
    logic o_s_tready, o_m_tvalid, o_m_tuser, o_m_tlast, o_cfg_ready;
    logic [PIX_W-1:0] o_m_tdata;

    edge_scoreboard edges = new();
    bit   stim_done = 0;
    // While set, the result side holds off so the block backs up.
    bit   hold_results = 0;
    int   fill_mode = 0;

    sobel_edge_magnitude_rgb_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Sends one input beat after a random gap, or none.
    // The block is not ready again in the cycle after it takes a beat, so
    // dropping tvalid there costs no throughput.
    task automatic send_beat(bit flush, logic [23:0] rgb, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (fill_mode ? 0 : $urandom_range(0, 19));
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= flush;
        i_s_tdata <= rgb;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        edges.note_input(flush, rgb);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [DIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        edges.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Lets every queued result drain, then idles for beats that cause no
    // result but may still be in progress.
    task automatic wait_drain();
        while (edges.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    // Pushes one whole frame, optionally with early flushes and stray pixels,
    // then flushes until the frame's last result is out.
    task automatic run_frame(int w, int h, bit noisy);
        for (int k = 0; k < w * h; k++)
            send_beat(noisy && $urandom_range(0, 15) == 0, rand_pixel());
        while (!edges.at_frame_start())
            send_beat(!(noisy && $urandom_range(0, 3) == 0), rand_pixel());
    endtask

    task automatic set_size(int w, int h);
        wait_drain();
        write_reg(CFG_FRAME_WIDTH, DIM_W'(w));
        write_reg(CFG_FRAME_HEIGHT, DIM_W'(h));
    endtask

    // Result side: random stalls, often none, and a long hold.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            if (hold_results) begin
                i_m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_results = 0;
            end
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    // Result beats are checked at the edge they are accepted.
    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready)
            edges.check_result(o_m_tdata, o_m_tuser, o_m_tlast);

    initial begin
        int w, h, n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle flush, a 1x1 frame, extreme values, clamping.
        send_beat(1'b1, 24'hffffff);
        set_size(0, 0);
        send_beat(1'b0, 24'hffffff);
        set_size(3, 3);
        send_beat(1'b0, 24'hffffff);
        send_beat(1'b1, 24'h123456);
        for (int k = 0; k < 7; k++) send_beat(1'b0, (k % 2) ? 24'h000000 : 24'hffffff);
        while (!edges.at_frame_start()) send_beat(1'b0, 24'hff00ff);
        set_size(2047, 1);
        send_beat(1'b0, 24'h80ff01);
        send_beat(1'b1, 24'h0);
        set_size(2, 2047);
        send_beat(1'b0, 24'h7f0080);
        send_beat(1'b0, 24'hfe01ff);

        // Register change mid-frame: narrow the row and shorten the frame
        // while the block is idle.
        wait_drain();
        write_reg(CFG_FRAME_WIDTH, 11'd1);
        write_reg(CFG_FRAME_HEIGHT, 11'd2);
        while (!edges.at_frame_start()) send_beat(1'b1, 24'h0);

        // Back pressure: hold the result side while beats keep coming.
        set_size(6, 4);
        hold_results = 1;
        fill_mode = 1;
        run_frame(6, 4, 0);
        fill_mode = 0;

        // Random frames, mostly small.
        n = 0;
        while (n < 1350) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 9);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 7);
            set_size(w, h);
            run_frame(w, h, $urandom_range(0, 3) == 0);
            n += w * h + w + 1;
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        wait (edges.pending.size() == 0);
        repeat (50) @(posedge i_clk);
        if (edges.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire
